// File: hw/rtl/assert_macros.svh
// assertion macros shared by the parser rtl
// no dependencies; each macro is empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/dccp_pkg.sv
// types and constants shared by the cnf token parser modules
// no dependencies
`timescale 1ns / 1ps

package dccp_pkg;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// sticky error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_CHAR     = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;
	localparam logic [1:0] ERR_EOF      = 2'd3;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_NEWLINE,
		CLS_DIGIT,
		CLS_MINUS,
		CLS_PLUS,
		CLS_SKIP,
		CLS_OTHER,
		CLS_EOF
	} tok_cls_t;

	typedef struct packed {
		tok_cls_t   cls;
		logic [3:0] digit;
	} tok_t;

	typedef struct packed {
		logic valid;
		tok_t tok;
	} q_head_t;

endpackage

// File: hw/rtl/dccp_front.sv
// front end: accepts text items and classifies each byte into a token
// depends on dccp_pkg
`timescale 1ns / 1ps

module dccp_front import dccp_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,   // end_of_input
	input  logic       full,
	output logic       push,
	output tok_t       tok
);

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		tok.digit = s_tdata[3:0];
		if (s_tlast) begin
			tok.cls = CLS_EOF;
		end else if (s_tdata == CH_NL) begin
			tok.cls = CLS_NEWLINE;
		end else if (s_tdata inside {[CH_TAB:CH_CR], CH_SP}) begin
			tok.cls = CLS_SPACE;
		end else if (s_tdata inside {[CH_ZERO:CH_NINE]}) begin
			tok.cls = CLS_DIGIT;
		end else if (s_tdata == CH_MINUS) begin
			tok.cls = CLS_MINUS;
		end else if (s_tdata == CH_PLUS) begin
			tok.cls = CLS_PLUS;
		end else if (s_tdata inside {CH_C, CH_P}) begin
			tok.cls = CLS_SKIP;
		end else begin
			tok.cls = CLS_OTHER;
		end
	end

endmodule

// File: hw/rtl/dccp_fifo.sv
// short token queue between the classifier and the parser
// depends on dccp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dccp_fifo import dccp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  tok_t    push_tok,
	input  logic    pop,
	output logic    full,
	output q_head_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	tok_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full       = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= (PTR_W+1)'(QUEUE_DEPTH))
	`ASSERT_IMPLY(a_no_pop_empty, clk, arst_n, pop, cnt_q != '0)
	`ASSERT_ALWAYS(a_ptr_gap, clk, arst_n, PTR_W'(wr_ptr_q - rd_ptr_q) == cnt_q[PTR_W-1:0])

endmodule

// File: hw/rtl/dccp_back.sv
// back end: clause parser state machine with registered result output
// depends on dccp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dccp_back import dccp_pkg::*; #(
	parameter int VAR_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  q_head_t             head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_lv,
	output logic [VAR_BITS:0]   out_code,
	output logic                out_ce,
	output logic [1:0]          out_err,
	output logic                out_fin,
	output logic [VAR_BITS-1:0] out_maxv
);

	localparam int NV_W = VAR_BITS + 4;

	typedef enum logic [2:0] {
		MODE_BETWEEN,
		MODE_SKIPLINE,
		MODE_EXPECT,
		MODE_SIGN,
		MODE_DIGITS,
		MODE_HALT
	} mode_t;

	mode_t               mode_q, mode_d, mode_w;
	logic                neg_q, neg_d;
	logic [VAR_BITS-1:0] acc_q, acc_d;
	logic [VAR_BITS-1:0] maxv_q, maxv_d;
	logic [1:0]          err_q, err_d;

	logic                out_valid_q, out_lv_q, out_ce_q, out_fin_q;
	logic [VAR_BITS:0]   out_code_q;
	logic [1:0]          out_err_q;
	logic [VAR_BITS-1:0] out_maxv_q;

	logic                lv, ce, fin, done, do_expect;
	logic [VAR_BITS:0]   code;
	logic                eof, space, digit;
	logic [NV_W-1:0]     nv;

	assign eof   = (head.tok.cls == CLS_EOF);
	assign space = (head.tok.cls == CLS_SPACE) || (head.tok.cls == CLS_NEWLINE);
	assign digit = (head.tok.cls == CLS_DIGIT);
	assign nv    = NV_W'({acc_q, 3'b000}) + NV_W'({acc_q, 1'b0}) + NV_W'(head.tok.digit);

	assign pop = head.valid && (!out_valid_q || out_ready);

	always_comb begin
		mode_d = mode_q;
		neg_d  = neg_q;
		acc_d  = acc_q;
		maxv_d = maxv_q;
		err_d  = err_q;
		lv     = 1'b0;
		ce     = 1'b0;
		fin    = 1'b0;
		done   = 1'b0;
		code   = '0;
		mode_w = mode_q;

		// a number ends on any non-digit, which is then parsed again
		if (mode_q == MODE_DIGITS) begin
			if (digit) begin
				done = 1'b1;
				if (nv[NV_W-1:VAR_BITS] != '0) begin
					err_d  = ERR_OVERFLOW;
					mode_d = MODE_HALT;
					fin    = 1'b1;
				end else begin
					acc_d = nv[VAR_BITS-1:0];
				end
			end else begin
				if (acc_q == '0) begin
					ce     = 1'b1;
					mode_w = MODE_BETWEEN;
				end else begin
					lv   = 1'b1;
					code = {acc_q, ~neg_q};
					if (acc_q > maxv_q) begin
						maxv_d = acc_q;
					end
					mode_w = MODE_EXPECT;
				end
				acc_d  = '0;
				neg_d  = 1'b0;
				mode_d = mode_w;
			end
		end

		do_expect = !done && ((mode_w == MODE_EXPECT) ||
			(mode_w == MODE_BETWEEN && !eof && !space && head.tok.cls != CLS_SKIP));

		if (!done) begin
			case (mode_w)
				MODE_BETWEEN: begin
					if (eof) begin
						mode_d = MODE_HALT;
						fin    = 1'b1;
					end else if (head.tok.cls == CLS_SKIP) begin
						mode_d = MODE_SKIPLINE;
					end
				end
				MODE_SKIPLINE: begin
					if (eof) begin
						mode_d = MODE_HALT;
						fin    = 1'b1;
					end else if (head.tok.cls == CLS_NEWLINE) begin
						mode_d = MODE_BETWEEN;
					end
				end
				MODE_SIGN: begin
					if (eof) begin
						err_d  = ERR_EOF;
						mode_d = MODE_HALT;
						fin    = 1'b1;
					end else if (digit) begin
						acc_d  = VAR_BITS'(head.tok.digit);
						mode_d = MODE_DIGITS;
					end else begin
						err_d  = ERR_CHAR;
						mode_d = MODE_HALT;
						fin    = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (do_expect) begin
			if (eof) begin
				err_d  = ERR_EOF;
				mode_d = MODE_HALT;
				fin    = 1'b1;
			end else if (space) begin
				mode_d = mode_w;
			end else if (head.tok.cls == CLS_MINUS || head.tok.cls == CLS_PLUS) begin
				neg_d  = (head.tok.cls == CLS_MINUS);
				mode_d = MODE_SIGN;
			end else if (digit) begin
				neg_d  = 1'b0;
				acc_d  = VAR_BITS'(head.tok.digit);
				mode_d = MODE_DIGITS;
			end else begin
				err_d  = ERR_CHAR;
				mode_d = MODE_HALT;
				fin    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_BETWEEN;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			maxv_q      <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
			out_lv_q    <= 1'b0;
			out_code_q  <= '0;
			out_ce_q    <= 1'b0;
			out_err_q   <= ERR_NONE;
			out_fin_q   <= 1'b0;
			out_maxv_q  <= '0;
		end else begin
			if (pop && mode_q != MODE_HALT) begin
				mode_q <= mode_d;
				neg_q  <= neg_d;
				acc_q  <= acc_d;
				maxv_q <= maxv_d;
				err_q  <= err_d;
			end
			// a new result replaces the one taken in the same cycle
			if (pop && mode_q != MODE_HALT && (lv || ce || fin)) begin
				out_valid_q <= 1'b1;
				out_lv_q    <= lv;
				out_code_q  <= code;
				out_ce_q    <= ce;
				out_err_q   <= err_d;
				out_fin_q   <= fin;
				out_maxv_q  <= maxv_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_lv    = out_lv_q;
	assign out_code  = out_code_q;
	assign out_ce    = out_ce_q;
	assign out_err   = out_err_q;
	assign out_fin   = out_fin_q;
	assign out_maxv  = out_maxv_q;

	`ASSERT_IMPLY(a_one_kind, clk, arst_n, out_valid_q, !(out_lv_q && out_ce_q))
	`ASSERT_IMPLY(a_err_fin, clk, arst_n, out_valid_q && out_err_q != ERR_NONE, out_fin_q)
	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, mode_q == MODE_HALT, mode_q == MODE_HALT)
	`ASSERT_IMPLY(a_acc_clear, clk, arst_n,
		mode_q == MODE_BETWEEN || mode_q == MODE_SKIPLINE || mode_q == MODE_EXPECT, acc_q == '0)

endmodule

// File: hw/rtl/dimacs_cnf_token_parser.sv
// DIMACS CNF token parser: one text byte per item in, at most one result per item out. The
// classifier takes a byte every clock into a four-entry token queue while it is not full; the
// parser pops one token per clock and writes results into an output register, so the block
// sustains one item per cycle while the output is taken; each item passes through the token
// queue, and its result is held in the output register. The rate is set by the parser's state
// update per character (one multiply-by-ten add and compare on the running number). After an
// end-of-input item or an error the block reports finished and drops further items until
// reset.
// depends on dccp_pkg, dccp_front, dccp_fifo, dccp_back
`timescale 1ns / 1ps

module dimacs_cnf_token_parser import dccp_pkg::*; #(
	parameter int VAR_BITS = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [7:0]                             s_tdata,  // [7:0] text_byte
	input  logic                                   s_tlast,  // end_of_input
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// literal_valid, literal_code, clause_end, error_code, max_variable, zero pad
	output logic [((2*VAR_BITS+5+7)/8)*8-1:0]      m_tdata,
	output logic                                   m_tlast   // finished
);

	localparam int OUT_W  = 2*VAR_BITS + 5;
	localparam int TDATA_W = ((OUT_W+7)/8)*8;

	logic                full, push, pop;
	tok_t                tok;
	q_head_t             head;
	logic                out_lv, out_ce, out_fin;
	logic [VAR_BITS:0]   out_code;
	logic [1:0]          out_err;
	logic [VAR_BITS-1:0] out_maxv;

	dccp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push),
		.tok      (tok)
	);

	dccp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (tok),
		.pop      (pop),
		.full     (full),
		.head     (head)
	);

	dccp_back #(
		.VAR_BITS (VAR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_lv    (out_lv),
		.out_code  (out_code),
		.out_ce    (out_ce),
		.out_err   (out_err),
		.out_fin   (out_fin),
		.out_maxv  (out_maxv)
	);

	assign m_tdata = TDATA_W'({out_maxv, out_err, out_ce, out_code, out_lv});
	assign m_tlast = out_fin;

endmodule
